// ===== hdl/csc_pkg.sv =====
// Shared types, constants and calendar tables for the calendar seconds converter.
// No dependencies.
package csc_pkg;

  typedef struct packed {
    logic        action;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
    logic [31:0] count_in;
  } csc_in_t;

  typedef struct packed {
    logic [31:0] count_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday;
    logic [8:0]  year_day;
    logic        invalid;
  } csc_out_t;

  typedef enum logic [2:0] {
    DIV_C100 = 3'd0,
    DIV_DAY  = 3'd1,
    DIV_HR   = 3'd2,
    DIV_MIN  = 3'd3,
    DIV_WK   = 3'd4
  } csc_div_sel_t;

  typedef struct packed {
    logic         start;
    logic [31:0]  dividend;
    csc_div_sel_t sel;
  } csc_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [16:0] rem;
  } csc_div_rsp_t;

  localparam logic        ACT_TO_SECS  = 1'b0;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [16:0] SECS_PER_HR  = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN = 17'd60;
  localparam logic [16:0] DAYS_PER_WK  = 17'd7;
  localparam logic [16:0] YEARS_PER_C  = 17'd100;
  localparam logic [31:0] EPOCH_DAY    = 32'd722815;
  localparam logic [13:0] EPOCH_YEAR   = 14'd1980;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd80;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd380;

  localparam logic [31:0] RECIP_C100 = 32'd42949672;
  localparam logic [31:0] RECIP_DAY  = 32'd49710;
  localparam logic [31:0] RECIP_HR   = 32'd1193046;
  localparam logic [31:0] RECIP_MIN  = 32'd71582788;
  localparam logic [31:0] RECIP_WK   = 32'd613566756;

  function automatic logic [16:0] div_const(input csc_div_sel_t sel);
    logic [16:0] v;
    case (sel)
      DIV_C100: v = YEARS_PER_C;
      DIV_DAY:  v = SECS_PER_DAY;
      DIV_HR:   v = SECS_PER_HR;
      DIV_MIN:  v = SECS_PER_MIN;
      DIV_WK:   v = DAYS_PER_WK;
      default:  v = DAYS_PER_WK;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] div_recip(input csc_div_sel_t sel);
    logic [31:0] v;
    case (sel)
      DIV_C100: v = RECIP_C100;
      DIV_DAY:  v = RECIP_DAY;
      DIV_HR:   v = RECIP_HR;
      DIV_MIN:  v = RECIP_MIN;
      DIV_WK:   v = RECIP_WK;
      default:  v = RECIP_WK;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] v;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
      4'd2:                                       v = leap ? 5'd29 : 5'd28;
      default:                                    v = 5'd0;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] days_before(input logic leap, input logic [3:0] m);
    logic [8:0] v;
    logic [8:0] l;
    l = {8'd0, leap};
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59 + l;
      4'd4:    v = 9'd90 + l;
      4'd5:    v = 9'd120 + l;
      4'd6:    v = 9'd151 + l;
      4'd7:    v = 9'd181 + l;
      4'd8:    v = 9'd212 + l;
      4'd9:    v = 9'd243 + l;
      4'd10:   v = 9'd273 + l;
      4'd11:   v = 9'd304 + l;
      4'd12:   v = 9'd334 + l;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/csc_div.sv =====
// Constant divider: reciprocal multiply on one shared 32x32 multiplier, then one
// correction step (states MULQ, MULR, SUB, FIX). Depends on csc_pkg.
module csc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csc_pkg::csc_div_req_t req,
  output csc_pkg::csc_div_rsp_t rsp
);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_MULQ = 5'b00010,
    D_MULR = 5'b00100,
    D_SUB  = 5'b01000,
    D_FIX  = 5'b10000
  } dstate_t;

  dstate_t     state_r, state_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] m_r, m_nxt;
  logic [16:0] d_r, d_nxt;
  logic [63:0] p_r, p_nxt;
  logic [31:0] q_r, q_nxt;
  logic [17:0] r_r, r_nxt;
  logic        done_r, done_nxt;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic        fit;

  assign mul_a = (state_r == D_MULQ) ? x_r : p_r[63:32];
  assign mul_b = (state_r == D_MULQ) ? m_r : {15'd0, d_r};
  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
  assign fit   = r_r >= {1'b0, d_r};

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    m_nxt     = m_r;
    d_nxt     = d_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      x_nxt     = req.dividend;
      m_nxt     = csc_pkg::div_recip(req.sel);
      d_nxt     = csc_pkg::div_const(req.sel);
      state_nxt = D_MULQ;
    end else begin
      case (state_r)
        D_IDLE: begin
          state_nxt = D_IDLE;
        end
        D_MULQ: begin
          p_nxt     = prod;
          state_nxt = D_MULR;
        end
        D_MULR: begin
          q_nxt     = p_r[63:32];
          p_nxt     = prod;
          state_nxt = D_SUB;
        end
        D_SUB: begin
          r_nxt     = 18'(x_r - p_r[31:0]);
          state_nxt = D_FIX;
        end
        D_FIX: begin
          if (fit) begin
            q_nxt = q_r + 32'd1;
            r_nxt = r_r - {1'b0, d_r};
          end
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
        default: begin
          state_nxt = D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    m_r <= m_nxt;
    d_r <= d_nxt;
    p_r <= p_nxt;
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r[16:0];

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == D_IDLE) else $error("divider done while running");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> r_r < {1'b0, d_r}) else $error("remainder not below divisor");
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> state_r == D_MULQ) else $error("divider did not start");

endmodule

// ===== hdl/calendar_seconds_converter_unit.sv =====
// Calendar seconds converter top level: sequencer around one shared constant divider.
// Depends on csc_pkg and csc_div.
//
// Usage: drive in_item and raise start; the transaction is taken on a rising edge
// with start high and busy low. busy stays high until the result is produced.
// action 0 turns a date and time into seconds since 1980-01-01 plus weekday and
// day of year (all zero with invalid set when a check fails); action 1 turns a
// seconds count into year, month, day, hour, minute and second.
// Each result appears on out_item for one cycle with out_valid high; the
// receiver takes it at the end of that cycle and cannot stall it.
// action 0 runs two divisions on the shared reciprocal divider (year by 100,
// then day number by 7 for the weekday); an invalid date or time ends after the
// first. action 1 runs three divisions (day, hour, minute), then steps one whole
// year at a time from 1980 and then one month at a time to reach the result.
// One transaction at a time; a new one is taken in the cycle out_valid shows.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops any
// transaction in flight.
module calendar_seconds_converter_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  csc_pkg::csc_in_t  in_item,
  output logic              out_valid,
  output csc_pkg::csc_out_t out_item
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_A0_DIV = 11'b00000000010,
    S_A0_DAY = 11'b00000000100,
    S_A0_SEC = 11'b00000001000,
    S_A0_WK  = 11'b00000010000,
    S_A1_DIV = 11'b00000100000,
    S_A1_HR  = 11'b00001000000,
    S_A1_MIN = 11'b00010000000,
    S_A1_YR  = 11'b00100000000,
    S_A1_MON = 11'b01000000000,
    S_A0_MUL = 11'b10000000000
  } state_t;

  state_t                state_r, state_nxt;
  csc_pkg::csc_in_t      in_r, in_nxt;
  csc_pkg::csc_out_t     out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  csc_pkg::csc_div_req_t dreq;
  csc_pkg::csc_div_rsp_t drsp;

  logic [22:0] ymul_r, ymul_nxt;
  logic [11:0] corr_r, corr_nxt;
  logic [8:0]  doy_r, doy_nxt;
  logic [22:0] dn_r, dn_nxt;
  logic [16:0] tod_r, tod_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [15:0] days_r, days_nxt;
  logic [13:0] yr_r, yr_nxt;
  logic [6:0]  m100_r, m100_nxt;
  logic [8:0]  m400_r, m400_nxt;
  logic [3:0]  mon_r, mon_nxt;

  logic        accept;
  logic [7:0]  cq, cq1;
  logic [6:0]  cr;
  logic        lp0, ok0;
  logic [13:0] ym1;
  logic        lp1;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [48:0] prod_full;
  logic [31:0] diff;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  csc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  assign cq  = drsp.quot[7:0];
  assign cr  = drsp.rem[6:0];
  assign lp0 = (in_r.year_in[1:0] == 2'd0) && ((cr != 7'd0) || (cq[1:0] == 2'd0));
  assign ok0 = (in_r.year_in != 14'd0) && (in_r.month_in >= 4'd1) &&
               (in_r.month_in <= 4'd12) && (in_r.day_in != 5'd0) &&
               (in_r.day_in <= csc_pkg::month_len(lp0, in_r.month_in)) &&
               (in_r.hour_in < 5'd24) && (in_r.minute_in < 6'd60) &&
               (in_r.second_in < 6'd60);
  assign cq1 = (cr != 7'd0) ? cq : 8'(cq - 8'd1);
  assign ym1 = 14'(in_r.year_in - 14'd1);

  assign lp1  = (yr_r[1:0] == 2'd0) && ((m100_r != 7'd0) || (m400_r == 9'd0));
  assign ylen = lp1 ? 9'd366 : 9'd365;
  assign mlen = csc_pkg::month_len(lp1, mon_r);

  assign diff      = {9'd0, dn_r} - csc_pkg::EPOCH_DAY;
  assign prod_full = {17'd0, diff} * {32'd0, csc_pkg::SECS_PER_DAY};

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    ymul_nxt      = ymul_r;
    corr_nxt      = corr_r;
    doy_nxt       = doy_r;
    dn_nxt        = dn_r;
    tod_nxt       = tod_r;
    prod_nxt      = prod_r;
    days_nxt      = days_r;
    yr_nxt        = yr_r;
    m100_nxt      = m100_r;
    m400_nxt      = m400_r;
    mon_nxt       = mon_r;
    dreq          = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_nxt  = in_item;
          out_nxt = '0;
          dreq.start = 1'b1;
          if (in_item.action == csc_pkg::ACT_TO_SECS) begin
            dreq.dividend = {18'd0, in_item.year_in};
            dreq.sel      = csc_pkg::DIV_C100;
            state_nxt     = S_A0_DIV;
          end else begin
            dreq.dividend = in_item.count_in;
            dreq.sel      = csc_pkg::DIV_DAY;
            state_nxt     = S_A1_DIV;
          end
        end
      end
      S_A0_DIV: begin
        if (drsp.done) begin
          if (!ok0) begin
            out_nxt.invalid = 1'b1;
            out_valid_nxt   = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            ymul_nxt  = 23'(ym1) * 23'd365;
            corr_nxt  = 12'({2'd0, ym1[13:2]} - {6'd0, cq1} + {8'd0, cq1[7:2]});
            doy_nxt   = csc_pkg::days_before(lp0, in_r.month_in) + {4'd0, in_r.day_in};
            state_nxt = S_A0_DAY;
          end
        end
      end
      S_A0_DAY: begin
        dn_nxt    = ymul_r + {11'd0, corr_r} + {14'd0, doy_r};
        tod_nxt   = 17'(in_r.hour_in) * 17'd3600 + 17'(in_r.minute_in) * 17'd60 +
                    {11'd0, in_r.second_in};
        state_nxt = S_A0_MUL;
      end
      S_A0_MUL: begin
        prod_nxt  = prod_full[31:0];
        state_nxt = S_A0_SEC;
      end
      S_A0_SEC: begin
        prod_nxt      = prod_r + {15'd0, tod_r};
        dreq.start    = 1'b1;
        dreq.dividend = {9'd0, 23'(dn_r - 23'd1)};
        dreq.sel      = csc_pkg::DIV_WK;
        state_nxt     = S_A0_WK;
      end
      S_A0_WK: begin
        if (drsp.done) begin
          out_nxt.count_out = prod_r;
          out_nxt.weekday   = 3'(drsp.rem[2:0] + 3'd1);
          out_nxt.year_day  = doy_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_A1_DIV: begin
        if (drsp.done) begin
          days_nxt      = drsp.quot[15:0];
          dreq.start    = 1'b1;
          dreq.dividend = {15'd0, drsp.rem};
          dreq.sel      = csc_pkg::DIV_HR;
          state_nxt     = S_A1_HR;
        end
      end
      S_A1_HR: begin
        if (drsp.done) begin
          out_nxt.hour_out = drsp.quot[4:0];
          dreq.start       = 1'b1;
          dreq.dividend    = {15'd0, drsp.rem};
          dreq.sel         = csc_pkg::DIV_MIN;
          state_nxt        = S_A1_MIN;
        end
      end
      S_A1_MIN: begin
        if (drsp.done) begin
          out_nxt.minute_out = drsp.quot[5:0];
          out_nxt.second_out = drsp.rem[5:0];
          yr_nxt             = csc_pkg::EPOCH_YEAR;
          m100_nxt           = csc_pkg::EPOCH_MOD100;
          m400_nxt           = csc_pkg::EPOCH_MOD400;
          state_nxt          = S_A1_YR;
        end
      end
      S_A1_YR: begin
        if (days_r >= {7'd0, ylen}) begin
          days_nxt = days_r - {7'd0, ylen};
          yr_nxt   = yr_r + 14'd1;
          m100_nxt = (m100_r == 7'd99) ? 7'd0 : 7'(m100_r + 7'd1);
          m400_nxt = (m400_r == 9'd399) ? 9'd0 : 9'(m400_r + 9'd1);
        end else begin
          mon_nxt   = 4'd1;
          state_nxt = S_A1_MON;
        end
      end
      S_A1_MON: begin
        if ((days_r >= {11'd0, mlen}) && (mon_r < 4'd12)) begin
          days_nxt = days_r - {11'd0, mlen};
          mon_nxt  = mon_r + 4'd1;
        end else begin
          out_nxt.year_out  = yr_r;
          out_nxt.month_out = mon_r;
          out_nxt.day_out   = 5'(days_r[4:0] + 5'd1);
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    out_r  <= out_nxt;
    ymul_r <= ymul_nxt;
    corr_r <= corr_nxt;
    doy_r  <= doy_nxt;
    dn_r   <= dn_nxt;
    tod_r  <= tod_nxt;
    prod_r <= prod_nxt;
    days_r <= days_nxt;
    yr_r   <= yr_nxt;
    m100_r <= m100_nxt;
    m400_r <= m400_nxt;
    mon_r  <= mon_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("transaction taken but not busy");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy) else $error("result shown while busy");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.invalid |-> out_r.count_out == 32'd0 &&
    out_r.weekday == 3'd0 && out_r.year_day == 9'd0)
    else $error("invalid result carries data");
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && in_r.action != csc_pkg::ACT_TO_SECS |->
    out_r.month_out >= 4'd1 && out_r.month_out <= 4'd12)
    else $error("month out of range");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result held for two cycles");

endmodule

// ===== verif/tb_calendar_seconds_converter_unit.sv =====
`timescale 1ns / 1ps
// Testbench for calendar_seconds_converter_unit: directed and random calendar/seconds
// conversions checked against an in-bench calendar predictor. Depends on csc_pkg.
module tb_calendar_seconds_converter_unit;

  localparam int STALL_LIMIT = 5000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  csc_pkg::csc_in_t  in_item;
  logic              out_valid;
  csc_pkg::csc_out_t out_item;

  csc_pkg::csc_out_t expected_q[$];
  int       mismatch_cnt;
  int       stall_cycles;
  int       to_secs_cnt;
  int       to_cal_cnt;
  int       invalid_cnt;
  int       result_cnt;
  bit       gaps_on;

  int unsigned mlen_tbl[2][13] = '{
    '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31},
    '{0, 31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31}};
  int unsigned ydays_tbl[2][14] = '{
    '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
    '{0, 0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}};

  calendar_seconds_converter_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int is_leap_year(longint unsigned y);
    if ((y & 3) != 0) return 0;
    if ((y % 100) != 0) return 1;
    return (((y / 100) & 3) == 0) ? 1 : 0;
  endfunction

  function automatic longint unsigned days_thru(longint unsigned y);
    return y * 365 + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic csc_pkg::csc_out_t convert_calendar(csc_pkg::csc_in_t t);
    csc_pkg::csc_out_t r;
    longint unsigned y, doy, dn, base, secs, c, days, rem, m;
    int              lp;
    bit              ok;
    r = '0;
    base = days_thru(1979) + 1;
    if (t.action == csc_pkg::ACT_TO_SECS) begin
      y  = t.year_in;
      lp = is_leap_year(y);
      ok = y >= 1 && t.month_in >= 1 && t.month_in <= 12 && t.day_in >= 1 &&
           t.hour_in < 24 && t.minute_in < 60 && t.second_in < 60;
      if (ok && t.day_in > mlen_tbl[lp][t.month_in]) ok = 0;
      if (!ok) begin
        r.invalid = 1'b1;
      end else begin
        doy  = ydays_tbl[lp][t.month_in] + t.day_in;
        dn   = days_thru(y - 1) + doy;
        secs = (dn - base) * 86400 + (t.hour_in * 60 + t.minute_in) * 60 + t.second_in;
        r.count_out = secs[31:0];
        r.weekday   = 3'(((dn - 1) % 7) + 1);
        r.year_day  = 9'(doy);
      end
    end else begin
      c    = t.count_in;
      days = c / 86400;
      rem  = c % 86400;
      dn   = base + days;
      y    = (dn * 400) / 146097 + 1;
      while (days_thru(y) < dn) y++;
      while (y > 1 && days_thru(y - 1) >= dn) y--;
      doy = dn - days_thru(y - 1);
      lp  = is_leap_year(y);
      m   = 12;
      while (m > 1 && doy <= ydays_tbl[lp][m]) m--;
      r.year_out   = 14'(y);
      r.month_out  = 4'(m);
      r.day_out    = 5'(doy - ydays_tbl[lp][m]);
      r.hour_out   = 5'(rem / 3600);
      r.minute_out = 6'((rem / 60) % 60);
      r.second_out = 6'(rem % 60);
    end
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(negedge clk) begin
    csc_pkg::csc_out_t e;
    if (out_valid === 1'b1) begin
      result_cnt++;
      if (expected_q.size() == 0) begin
        $error("result with no pending transaction");
        mismatch_cnt++;
      end else begin
        e = expected_q.pop_front();
        check_field("count_out", e.count_out, out_item.count_out);
        check_field("year_out", e.year_out, out_item.year_out);
        check_field("month_out", e.month_out, out_item.month_out);
        check_field("day_out", e.day_out, out_item.day_out);
        check_field("hour_out", e.hour_out, out_item.hour_out);
        check_field("minute_out", e.minute_out, out_item.minute_out);
        check_field("second_out", e.second_out, out_item.second_out);
        check_field("weekday", e.weekday, out_item.weekday);
        check_field("year_day", e.year_day, out_item.year_day);
        check_field("invalid", e.invalid, out_item.invalid);
      end
    end
  end

  always @(negedge clk) begin
    if (out_valid === 1'b1 || (start && busy === 1'b0)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("calendar_seconds_converter_unit verification failed");
      $finish;
    end
  end

  function automatic csc_pkg::csc_in_t noise_item();
    csc_pkg::csc_in_t t;
    t = csc_pkg::csc_in_t'(73'({$urandom, $urandom, $urandom}));
    return t;
  endfunction

  task automatic send_item(csc_pkg::csc_in_t t);
    csc_pkg::csc_out_t e;
    start   <= 1'b1;
    in_item <= t;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    e = convert_calendar(t);
    expected_q.push_back(e);
    if (t.action == csc_pkg::ACT_TO_SECS) to_secs_cnt++;
    else to_cal_cnt++;
    if (e.invalid) invalid_cnt++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start   <= 1'b0;
      in_item <= noise_item();
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic csc_pkg::csc_in_t date_item(int y, int m, int d, int h, int mi, int s);
    csc_pkg::csc_in_t t;
    t = noise_item();
    t.action    = csc_pkg::ACT_TO_SECS;
    t.year_in   = 14'(y);
    t.month_in  = 4'(m);
    t.day_in    = 5'(d);
    t.hour_in   = 5'(h);
    t.minute_in = 6'(mi);
    t.second_in = 6'(s);
    return t;
  endfunction

  function automatic csc_pkg::csc_in_t count_item(logic [31:0] c);
    csc_pkg::csc_in_t t;
    t = noise_item();
    t.action   = ~csc_pkg::ACT_TO_SECS;
    t.count_in = c;
    return t;
  endfunction

  function automatic csc_pkg::csc_in_t random_date();
    int y, m;
    case ($urandom_range(0, 3))
      0, 1:    y = $urandom_range(1980, 2116);
      2:       y = $urandom_range(1, 16383);
      default: y = $urandom_range(0, 1) ? $urandom_range(1, 3) * 400 : $urandom_range(1, 40) * 100;
    endcase
    m = $urandom_range(1, 12);
    return date_item(y, m, $urandom_range(1, mlen_tbl[is_leap_year(y)][m]),
                     $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  task automatic test_directed();
    send_item(date_item(1980, 1, 1, 0, 0, 0));
    send_item(date_item(1979, 12, 31, 23, 59, 59));
    send_item(date_item(2000, 2, 29, 12, 30, 45));
    send_item(date_item(1900, 2, 29, 0, 0, 0));
    send_item(date_item(2100, 2, 28, 23, 59, 59));
    send_item(date_item(2106, 2, 7, 6, 28, 15));
    send_item(date_item(1, 1, 1, 0, 0, 0));
    send_item(date_item(16383, 12, 31, 23, 59, 59));
    send_item(date_item(0, 1, 1, 0, 0, 0));
    send_item(date_item(2024, 0, 1, 0, 0, 0));
    send_item(date_item(2024, 13, 1, 0, 0, 0));
    send_item(date_item(2024, 15, 31, 31, 63, 63));
    send_item(date_item(2024, 3, 0, 0, 0, 0));
    send_item(date_item(2024, 4, 31, 0, 0, 0));
    send_item(date_item(2024, 5, 5, 24, 0, 0));
    send_item(date_item(2024, 5, 5, 0, 60, 0));
    send_item(date_item(2024, 5, 5, 0, 0, 60));
    send_item(count_item(32'd0));
    send_item(count_item(32'hFFFF_FFFF));
    send_item(count_item(32'd636_249_599));
    send_item(count_item(32'd636_249_600));
    send_item(count_item(32'd86399));
  endtask

  task automatic test_random(int n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_item(random_date());
        4, 5, 6:    send_item(count_item($urandom));
        default:    send_item(noise_item());
      endcase
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    mismatch_cnt = 0;
    stall_cycles = 0;
    to_secs_cnt  = 0;
    to_cal_cnt   = 0;
    invalid_cnt  = 0;
    result_cnt   = 0;
    gaps_on      = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1000);
    gaps_on = 1'b0;
    test_random(300);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d date-to-seconds (%0d invalid) and %0d seconds-to-date transactions",
             to_secs_cnt, invalid_cnt, to_cal_cnt);
    $display("checked %0d results, %0d field mismatches", result_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("calendar_seconds_converter_unit verification clean");
    end else begin
      $display("calendar_seconds_converter_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== calendar_seconds_converter_unit.f =====
hdl/csc_pkg.sv
hdl/csc_div.sv
hdl/calendar_seconds_converter_unit.sv
verif/tb_calendar_seconds_converter_unit.sv
